// File: rtl/sparse_linear_argmax_classifier_defines.svh
// Assertion helpers used by the checker file.
`ifndef SPARSE_LINEAR_ARGMAX_CLASSIFIER_DEFINES_SVH
`define SPARSE_LINEAR_ARGMAX_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/slac_pkg.sv
package slac_pkg;

    // Geometry of the weight table
    localparam int NUM_CATEGORIES = 8;
    localparam int VOCAB_SIZE     = 4096;

    localparam int CAT_W    = $clog2(NUM_CATEGORIES);
    localparam int COL_W    = $clog2(VOCAB_SIZE);
    localparam int SEL_W    = 3;
    localparam int INDEX_W  = 12;
    localparam int WEIGHT_W = 16;
    localparam int FREQ_W   = 16;
    localparam int PROD_W   = WEIGHT_W + FREQ_W + 1;
    localparam int SUM_W    = 40;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Input transaction
    typedef struct packed {
        logic                       mode;
        logic [SEL_W-1:0]           category_sel;
        logic [INDEX_W-1:0]         feature_index;
        logic signed [WEIGHT_W-1:0] weight_value;
        logic [FREQ_W-1:0]          frequency;
        logic                       last_feature;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [SEL_W-1:0]        best_category;
        logic signed [SUM_W-1:0] best_score;
    } out_item_t;

    // Item travelling down the cell chain
    typedef struct packed {
        logic                       valid;
        logic                       mode;
        logic [SEL_W-1:0]           cat;
        logic                       in_range;
        logic [COL_W-1:0]           col;
        logic signed [WEIGHT_W-1:0] weight;
        logic [FREQ_W-1:0]          freq;
        logic                       last;
    } token_t;

    // Running argmax handed from cell to cell
    typedef struct packed {
        logic                    valid;
        logic [CAT_W-1:0]        idx;
        logic signed [SUM_W-1:0] score;
    } best_t;

endpackage

// File: rtl/slac_ram.sv
module slac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/slac_cell.sv
module slac_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [slac_pkg::CAT_W-1:0] cell_id,
    input  slac_pkg::token_t           tok_in,
    output slac_pkg::token_t           tok_out,
    input  slac_pkg::best_t            best_in,
    output slac_pkg::best_t            best_out
);
    import slac_pkg::*;

    token_t                     s1_reg;
    token_t                     s1_next;
    logic                       wr_en;
    logic                       rd_en;
    logic signed [WEIGHT_W-1:0] weight_rd;
    logic signed [FREQ_W:0]     freq_s;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic                       s2_valid_reg;
    logic                       s2_valid_next;
    logic                       s2_add_reg;
    logic                       s2_add_next;
    logic                       s2_last_reg;
    logic                       s2_last_next;
    logic signed [SUM_W:0]      addend;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;
    logic signed [SUM_W-1:0]    acc_reg;
    logic signed [SUM_W-1:0]    acc_next;
    best_t                      best_reg;
    best_t                      best_next;

    // Weight bank for this category: loads write, features read
    assign wr_en = en & tok_in.valid & ~tok_in.mode & tok_in.in_range
                 & (CAT_W'(tok_in.cat) == cell_id);
    assign rd_en = en & tok_in.valid & tok_in.mode;

    slac_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (VOCAB_SIZE)
    ) u_bank (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tok_in.col),
        .wr_data (tok_in.weight),
        .rd_en   (rd_en),
        .rd_addr (tok_in.col),
        .rd_data (weight_rd)
    );

    // Stage 1: hold the transaction alongside the bank read
    assign s1_next = tok_in;
    assign tok_out = s1_reg;

    // Stage 2: weight times frequency
    assign freq_s        = $signed({1'b0, s1_reg.freq});
    assign prod_next     = weight_rd * freq_s;
    assign s2_valid_next = s1_reg.valid & s1_reg.mode;
    assign s2_add_next   = s1_reg.in_range;
    assign s2_last_next  = s1_reg.last;

    // Stage 3: saturating accumulate
    assign addend   = s2_add_reg ? {{(SUM_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg}
                                 : '0;
    assign sum_wide = {acc_reg[SUM_W-1], acc_reg} + addend;

    always_comb
    begin
        case (sum_wide[SUM_W:SUM_W-1])
            2'b01:   sum_sat = SUM_MAX;
            2'b10:   sum_sat = SUM_MIN;
            default: sum_sat = sum_wide[SUM_W-1:0];
        endcase
    end

    // Clear after the last feature of a document
    always_comb
    begin
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            acc_next = s2_last_reg ? '0 : sum_sat;
        end
    end

    // Merge into the running argmax; strictly greater wins, so ties keep the lower index
    always_comb
    begin
        best_next       = best_in;
        best_next.valid = s2_valid_reg & s2_last_reg;
        if ($signed(sum_sat) > $signed(best_in.score))
        begin
            best_next.idx   = cell_id;
            best_next.score = sum_sat;
        end
    end

    assign best_out = best_reg;

    // Advance every stage together unless the chain is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_valid_reg <= 1'b0;
            s2_add_reg   <= 1'b0;
            s2_last_reg  <= 1'b0;
            acc_reg      <= '0;
            best_reg     <= '0;
        end
        else if (en)
        begin
            s1_reg       <= s1_next;
            s2_valid_reg <= s2_valid_next;
            s2_add_reg   <= s2_add_next;
            s2_last_reg  <= s2_last_next;
            acc_reg      <= acc_next;
            best_reg     <= best_next;
        end
    end

    // Product payload needs no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// File: rtl/sparse_linear_argmax_classifier.sv
// Path: a document's last feature transaction passes through each cell's token register,
//   then the last cell's product register, its argmax register and the output register.
// Throughput: one transaction per cycle; the chain holds only while a stalled result
//   waits and the next one has reached the end of the cell chain.
// Reset: rst_n clears accumulators and valid flags at once; weights stay unknown
//   until loaded.
module sparse_linear_argmax_classifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  slac_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output slac_pkg::out_item_t result
);
    import slac_pkg::*;

    token_t    tok [NUM_CATEGORIES+1];
    best_t     best [NUM_CATEGORIES+1];
    best_t     res;
    logic      col_ok;
    logic      cat_ok;
    logic      freeze;
    logic      en;
    logic      out_load;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    // Range checks on the incoming transaction
    assign col_ok = 32'(item.feature_index) < 32'(VOCAB_SIZE);
    assign cat_ok = 32'(item.category_sel) < 32'(NUM_CATEGORIES);

    // Head of the chain
    always_comb
    begin
        tok[0].valid    = item_valid;
        tok[0].mode     = item.mode;
        tok[0].cat      = item.category_sel;
        tok[0].in_range = item.mode ? col_ok : (col_ok & cat_ok);
        tok[0].col      = COL_W'(item.feature_index);
        tok[0].weight   = item.weight_value;
        tok[0].freq     = item.frequency;
        tok[0].last     = item.last_feature;
    end

    assign best[0].valid = 1'b0;
    assign best[0].idx   = '0;
    assign best[0].score = SUM_MIN;

    // One cell per category
    for (genvar i = 0; i < NUM_CATEGORIES; i++)
    begin : g_cell
        slac_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_id  (CAT_W'(i)),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .best_in  (best[i]),
            .best_out (best[i+1])
        );
    end

    assign res = best[NUM_CATEGORIES];

    // Hold the chain only when a new result would overrun a stalled one
    assign freeze     = out_valid_reg & result_stall & res.valid;
    assign en         = ~freeze;
    assign item_stall = freeze;

    // Output register
    assign out_load                    = ~(out_valid_reg & result_stall);
    assign out_valid_next              = out_load ? res.valid : out_valid_reg;
    assign out_data_next.best_category = SEL_W'(res.idx);
    assign out_data_next.best_score    = res.score;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// File: rtl/slac_checker.sv
`include "sparse_linear_argmax_classifier_defines.svh"

module slac_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input slac_pkg::in_item_t  item,
    input logic                result_valid,
    input logic                result_stall,
    input slac_pkg::out_item_t result
);
    import slac_pkg::*;

    localparam int PEND_W = $clog2(NUM_CATEGORIES + 8) + 1;

    logic              doc_in;
    logic              doc_out;
    logic              res_wait;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;

    // Count documents closed at the input and not yet delivered
    assign doc_in    = item_valid & ~item_stall & item.mode & item.last_feature;
    assign doc_out   = result_valid & ~result_stall;
    assign pend_next = pend_reg + PEND_W'(doc_in) - PEND_W'(doc_out);

    // Flag a result waiting on a stall
    assign res_wait = result_valid & result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `SLAC_ASSERT_NXT(a_result_hold, res_wait, result_valid && $stable(result), "result not held")
    `SLAC_ASSERT_IMP(a_no_orphan, result_valid, pend_reg != '0, "result without a closed document")
    `SLAC_ASSERT_IMP(a_stall_cause, item_stall, res_wait, "input stalled with no result waiting")

endmodule

bind sparse_linear_argmax_classifier slac_checker u_checker (.*);
